@@ rtl/srf_pkg.sv @@
// Shared constants and types for the SPI register-file command slave.
`timescale 1ns / 1ps
package srf_pkg;

  localparam int REG_COUNT = 128;
  localparam int ADDR_W    = $clog2(REG_COUNT);

  localparam logic [7:0] CMD_CLEAR  = 8'hC0;
  localparam logic [7:0] CMD_WRITE  = 8'h02;
  localparam logic [7:0] CMD_READ   = 8'h03;
  localparam logic [7:0] CMD_BITMOD = 8'h05;

  typedef enum logic [5:0] {
    PH_CMD     = 6'b000001,
    PH_ADDR    = 6'b000010,
    PH_STREAM  = 6'b000100,
    PH_MASK    = 6'b001000,
    PH_BITDATA = 6'b010000,
    PH_IGNORE  = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_READ,
    OP_WRITE,
    OP_BITMOD,
    OP_CLEAR
  } op_t;

endpackage

@@ rtl/spi_register_file_command_slave.sv @@
// SPI register-file command slave: frame decode, register memory and result buffer.
// Throughput: one word per cycle unless the result buffer is full; decode, memory read
// and read-modify-write are pipelined, a result passing stage 1, then the result buffer.
// A two-word result buffer lets input continue while a result waits.
// Reset (synchronous, rst_n low): frame returns to awaiting command, every
// register reads as zero at once (per-entry valid bits), pipeline and buffer empty.
`timescale 1ns / 1ps
module spi_register_file_command_slave (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_mosi_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_miso_byte
);

  localparam int AW = srf_pkg::ADDR_W;

  // frame state
  srf_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      cmd_r, cmd_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [7:0]      mask_r, mask_nxt;
  srf_pkg::op_t    op_nxt;

  // stage 1
  logic            s1_v_r;
  srf_pkg::op_t    s1_op_r;
  logic [AW-1:0]   s1_addr_r;
  logic [7:0]      s1_data_r;
  logic [7:0]      s1_mask_r;

  // memory
  logic [7:0]                 mem [srf_pkg::REG_COUNT];
  logic [srf_pkg::REG_COUNT-1:0] vld_r;
  logic [7:0]                 rd_q_r;

  // write forwarding
  logic          fwd_v_r;
  logic [AW-1:0] fwd_addr_r;
  logic [7:0]    fwd_data_r;

  logic       wr_en;
  logic [7:0] wr_data;
  logic [7:0] cur;
  logic [7:0] res;

  // result buffer
  logic [7:0] q0_r, q1_r, q0_nxt, q1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop, acc;

  assign acc = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    addr_nxt  = addr_r;
    mask_nxt  = mask_r;
    op_nxt    = srf_pkg::OP_NONE;
    if (in_kind) begin
      phase_nxt = srf_pkg::PH_CMD;
    end else begin
      case (phase_r)
        srf_pkg::PH_CMD: begin
          cmd_nxt = in_mosi_byte;
          if (in_mosi_byte == srf_pkg::CMD_CLEAR) begin
            op_nxt    = srf_pkg::OP_CLEAR;
            phase_nxt = srf_pkg::PH_IGNORE;
          end else if (in_mosi_byte inside {srf_pkg::CMD_WRITE, srf_pkg::CMD_READ,
                                             srf_pkg::CMD_BITMOD}) begin
            phase_nxt = srf_pkg::PH_ADDR;
          end else begin
            phase_nxt = srf_pkg::PH_IGNORE;
          end
        end
        srf_pkg::PH_ADDR: begin
          addr_nxt  = in_mosi_byte[AW-1:0];
          phase_nxt = (cmd_r == srf_pkg::CMD_BITMOD) ? srf_pkg::PH_MASK : srf_pkg::PH_STREAM;
        end
        srf_pkg::PH_STREAM: begin
          op_nxt   = (cmd_r == srf_pkg::CMD_READ) ? srf_pkg::OP_READ : srf_pkg::OP_WRITE;
          addr_nxt = addr_r + AW'(1);
        end
        srf_pkg::PH_MASK: begin
          mask_nxt  = in_mosi_byte;
          phase_nxt = srf_pkg::PH_BITDATA;
        end
        srf_pkg::PH_BITDATA: begin
          op_nxt    = srf_pkg::OP_BITMOD;
          phase_nxt = srf_pkg::PH_IGNORE;
        end
        default: begin
          phase_nxt = srf_pkg::PH_IGNORE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= srf_pkg::PH_CMD;
      cmd_r   <= '0;
      addr_r  <= '0;
      mask_r  <= '0;
      s1_v_r  <= 1'b0;
      s1_op_r <= srf_pkg::OP_NONE;
    end else begin
      s1_v_r <= acc;
      if (acc) begin
        phase_r <= phase_nxt;
        cmd_r   <= cmd_nxt;
        addr_r  <= addr_nxt;
        mask_r  <= mask_nxt;
        s1_op_r <= op_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr_r <= addr_r;
      s1_data_r <= in_mosi_byte;
      s1_mask_r <= mask_r;
    end
  end

  // stage 1: merge memory, valid bits and forwarded write
  always_comb begin
    if (fwd_v_r && (fwd_addr_r == s1_addr_r)) begin
      cur = fwd_data_r;
    end else if (vld_r[s1_addr_r]) begin
      cur = rd_q_r;
    end else begin
      cur = '0;
    end
    wr_en   = s1_v_r && ((s1_op_r == srf_pkg::OP_WRITE) || (s1_op_r == srf_pkg::OP_BITMOD));
    wr_data = (s1_op_r == srf_pkg::OP_WRITE) ? s1_data_r
                                             : ((cur & ~s1_mask_r) | (s1_data_r & s1_mask_r));
    res     = (s1_op_r == srf_pkg::OP_READ) ? cur : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr_r] <= wr_data;
    end
    if (acc) begin
      rd_q_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      fwd_v_r <= 1'b0;
    end else begin
      fwd_v_r <= wr_en;
      if (s1_v_r && (s1_op_r == srf_pkg::OP_CLEAR)) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= wr_data;
  end

  // two-word result buffer
  assign push = s1_v_r;
  assign pop  = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    if (pop) begin
      q0_nxt = (cnt_r == 2'd2) ? q1_r : res;
    end else if (cnt_r == 2'd0) begin
      q0_nxt = res;
    end
    if (push && (((cnt_r == 2'd1) && !pop) || ((cnt_r == 2'd2) && pop))) begin
      q1_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

  assign in_ready      = (cnt_nxt != 2'd2);
  assign out_valid     = (cnt_r != 2'd0);
  assign out_miso_byte = q0_r;

endmodule

@@ rtl/srf_checker.sv @@
// Port-level checks for the SPI register-file command slave, bound to the top level.
`timescale 1ns / 1ps
module srf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_miso_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_miso_byte))
    else $error("result word changed while stalled");

  a_stall_backed: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_rise_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an input word two cycles earlier");

endmodule

bind spi_register_file_command_slave srf_checker u_srf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_miso_byte (out_miso_byte)
);

@@ tb/sv/tb_spi_register_file_command_slave.sv @@
// Self-checking bench for the SPI register-file slave: directed and random frames vs a shadow file.
`timescale 1ns / 1ps
module tb_spi_register_file_command_slave;

  localparam int AW = srf_pkg::ADDR_W;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;
  localparam logic CHK_FIXED    = 1'b1;
  localparam logic CHK_PRED     = 1'b0;

  localparam int DIR_N        = 32;
  localparam int RANDOM_WORDS = 1450;
  localparam int QUIET_LO     = 400;
  localparam int QUIET_HI     = 700;
  localparam int HOLD_AT      = 900;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic       kind;
    logic [7:0] mosi;
    logic       fixed;
    logic [7:0] miso;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_kind = 1'b0;
  logic [7:0] in_mosi_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_miso_byte;

  dir_row_t          directed_rows [DIR_N];
  logic [7:0]        miso_pending_q [$];
  logic [7:0]        shadow_regs [srf_pkg::REG_COUNT];
  srf_pkg::phase_t   shadow_phase = srf_pkg::PH_CMD;
  logic [7:0]        shadow_cmd = 8'h00;
  logic [AW-1:0]     shadow_addr = '0;
  logic [7:0]        shadow_mask = 8'h00;
  int                words_sent = 0;
  int                results_seen = 0;
  int                error_count = 0;
  int                stall_count = 0;

  spi_register_file_command_slave DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_mosi_byte (in_mosi_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_miso_byte(out_miso_byte)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] shadow_exchange(logic kind, logic [7:0] b);
    logic [7:0]    miso;
    logic [AW-1:0] a;
    miso = 8'h00;
    a = shadow_addr;
    if (kind == KIND_RELEASE) begin
      shadow_phase = srf_pkg::PH_CMD;
      return 8'h00;
    end
    case (shadow_phase)
      srf_pkg::PH_CMD: begin
        shadow_cmd = b;
        if (b == srf_pkg::CMD_CLEAR) begin
          foreach (shadow_regs[i]) shadow_regs[i] = 8'h00;
          shadow_phase = srf_pkg::PH_IGNORE;
        end else if (b == srf_pkg::CMD_WRITE || b == srf_pkg::CMD_READ ||
                     b == srf_pkg::CMD_BITMOD) begin
          shadow_phase = srf_pkg::PH_ADDR;
        end else begin
          shadow_phase = srf_pkg::PH_IGNORE;
        end
      end
      srf_pkg::PH_ADDR: begin
        shadow_addr = AW'(b % srf_pkg::REG_COUNT);
        shadow_phase = (shadow_cmd == srf_pkg::CMD_BITMOD) ? srf_pkg::PH_MASK
                                                           : srf_pkg::PH_STREAM;
      end
      srf_pkg::PH_STREAM: begin
        if (shadow_cmd == srf_pkg::CMD_READ) miso = shadow_regs[a];
        else shadow_regs[a] = b;
        shadow_addr = AW'((a + 1) % srf_pkg::REG_COUNT);
      end
      srf_pkg::PH_MASK: begin
        shadow_mask = b;
        shadow_phase = srf_pkg::PH_BITDATA;
      end
      srf_pkg::PH_BITDATA: begin
        shadow_regs[a] = (shadow_regs[a] & ~shadow_mask) | (b & shadow_mask);
        shadow_phase = srf_pkg::PH_IGNORE;
      end
      default: ;
    endcase
    return miso;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t %s: got %02h want %02h", $time, what, got, want);
    error_count++;
  endtask

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(logic kind, logic [7:0] b, logic fixed, logic [7:0] fixed_miso);
    logic [7:0] want;
    while (!(words_sent >= QUIET_LO && words_sent < QUIET_HI) && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_mosi_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = shadow_exchange(kind, b);
    miso_pending_q.push_back(fixed ? fixed_miso : want);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    send_word(KIND_BYTE, b, CHK_PRED, 8'h00);
  endtask

  function automatic logic [7:0] pick_addr();
    case ($urandom_range(2))
      0: return 8'($urandom_range(255));
      1: return 8'($urandom_range(15));
      default: return 8'($urandom_range(7) + 8'h78 + ($urandom_range(1) ? 8'h80 : 8'h00));
    endcase
  endfunction

  task automatic random_frame();
    int         pick;
    logic [7:0] cmd;
    pick = $urandom_range(99);
    if (pick < 33) begin
      send_byte(srf_pkg::CMD_WRITE);
      send_byte(pick_addr());
      repeat ($urandom_range(6)) send_byte(8'($urandom));
    end else if (pick < 63) begin
      send_byte(srf_pkg::CMD_READ);
      send_byte(pick_addr());
      repeat ($urandom_range(6)) send_byte(8'($urandom));
    end else if (pick < 81) begin
      send_byte(srf_pkg::CMD_BITMOD);
      send_byte(pick_addr());
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      repeat ($urandom_range(2)) send_byte(8'($urandom));
    end else if (pick < 84) begin
      send_byte(srf_pkg::CMD_CLEAR);
      repeat ($urandom_range(2)) send_byte(8'($urandom));
    end else if (pick < 91) begin
      do cmd = 8'($urandom);
      while (cmd == srf_pkg::CMD_CLEAR || cmd == srf_pkg::CMD_WRITE ||
             cmd == srf_pkg::CMD_READ || cmd == srf_pkg::CMD_BITMOD);
      send_byte(cmd);
      repeat ($urandom_range(3)) send_byte(8'($urandom));
    end else begin
      case ($urandom_range(2))
        0: cmd = srf_pkg::CMD_WRITE;
        1: cmd = srf_pkg::CMD_READ;
        default: cmd = srf_pkg::CMD_BITMOD;
      endcase
      send_byte(cmd);
      repeat ($urandom_range(2)) send_byte(8'($urandom));
    end
    if ($urandom_range(9) != 0) send_word(KIND_RELEASE, 8'($urandom), CHK_PRED, 8'h00);
    if ($urandom_range(29) == 0) send_word(KIND_RELEASE, 8'($urandom), CHK_PRED, 8'h00);
  endtask

  initial begin
    bit held = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (results_seen >= QUIET_LO && results_seen < QUIET_HI) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 8);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (miso_pending_q.size() == 0) begin
        report_mismatch("miso word with nothing pending", out_miso_byte, 8'h00);
      end else begin
        if (out_miso_byte !== miso_pending_q[0])
          report_mismatch("miso_byte", out_miso_byte, miso_pending_q[0]);
        void'(miso_pending_q.pop_front());
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_count <= 0;
    else stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("tb_spi_register_file_command_slave: errors");
      $finish;
    end
  end

  initial begin
    directed_rows = '{
      '{KIND_RELEASE, 8'hFF,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    srf_pkg::CMD_READ,   CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'h7F,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'hFF,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'h00,              CHK_FIXED, 8'h00},
      '{KIND_RELEASE, 8'h00,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    srf_pkg::CMD_WRITE,  CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'hFF,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'hA5,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'h5A,              CHK_FIXED, 8'h00},
      '{KIND_RELEASE, 8'h00,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    srf_pkg::CMD_BITMOD, CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'h7F,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'hF0,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'h0F,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'h33,              CHK_FIXED, 8'h00},
      '{KIND_RELEASE, 8'h00,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    srf_pkg::CMD_READ,   CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'hFF,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'h00,              CHK_PRED,  8'h00},
      '{KIND_BYTE,    8'hFF,              CHK_PRED,  8'h00},
      '{KIND_RELEASE, 8'h00,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    srf_pkg::CMD_CLEAR,  CHK_FIXED, 8'h00},
      '{KIND_BYTE,    srf_pkg::CMD_READ,   CHK_FIXED, 8'h00},
      '{KIND_RELEASE, 8'h00,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'hFF,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    srf_pkg::CMD_WRITE,  CHK_FIXED, 8'h00},
      '{KIND_RELEASE, 8'h00,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    srf_pkg::CMD_READ,   CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'h80,              CHK_FIXED, 8'h00},
      '{KIND_BYTE,    8'h00,              CHK_PRED,  8'h00},
      '{KIND_RELEASE, 8'h00,              CHK_FIXED, 8'h00}
    };
    foreach (shadow_regs[i]) shadow_regs[i] = 8'h00;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[i])
      send_word(directed_rows[i].kind, directed_rows[i].mosi,
                directed_rows[i].fixed, directed_rows[i].miso);
    while (words_sent < DIR_N + RANDOM_WORDS) random_frame();
    in_valid <= 1'b0;
    while (miso_pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("tb_spi_register_file_command_slave: clean");
    else $display("tb_spi_register_file_command_slave: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/srf_pkg.sv
rtl/spi_register_file_command_slave.sv
rtl/srf_checker.sv
tb/sv/tb_spi_register_file_command_slave.sv
